[rtl/plpb_pkg.sv]
package plpb_pkg;

	localparam int PCT_W    = 16;
	localparam int RAW_W    = 8;
	localparam int PT_W     = 24;
	localparam int PAIR_W   = 48;
	localparam int PAIRS    = 4;
	localparam int CNT_W    = 4;
	localparam int IDX_W    = 3;
	localparam int QUO_W    = 8;
	localparam int NUM_W    = 25;
	localparam int DEN_W    = 17;
	localparam int LIN_W    = 24;

	localparam logic [LIN_W-1:0] LIN_BIAS  = 24'd12800;
	localparam logic [DEN_W-1:0] LIN_DEN   = 17'd25600;
	localparam logic [PCT_W-1:0] LIN_SAT_P = 16'd25651;
	localparam logic [RAW_W-1:0] RAW_MAX   = 8'd255;

	localparam logic [PAIR_W-1:0] PAIR0_RST = 48'd27488428228608;
	localparam logic [PAIR_W-1:0] PAIR1_RST = 48'd80265794945087;
	localparam logic [PAIR_W-1:0] PAIR2_RST = 48'd6553700;
	localparam logic [PAIR_W-1:0] PAIR3_RST = 48'd0;
	localparam logic [CNT_W-1:0]  COUNT_RST = 4'd5;

	typedef enum logic [IDX_W-1:0] {
		REG_IDENTITY = 3'd0,
		REG_COUNT    = 3'd1,
		REG_PAIR0    = 3'd2,
		REG_PAIR1    = 3'd3,
		REG_PAIR2    = 3'd4,
		REG_PAIR3    = 3'd5
	} cfg_reg_t;

	typedef logic [PAIRS-1:0][PAIR_W-1:0] pairs_t;

	typedef struct packed {
		logic             dir;
		logic             lin;
		logic [RAW_W-1:0] val;
		logic [PCT_W-1:0] p;
		logic [PCT_W-1:0] ap;
		logic [PCT_W-1:0] bp;
		logic [RAW_W-1:0] ar;
		logic [RAW_W-1:0] br;
	} seg_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
	} div_t;

endpackage

[rtl/piecewise_linear_percent_to_byte_core.sv]
// Pipeline: segment select, three arithmetic stages, eight restoring divide stages.
// Throughput: one request per cycle; each stage holds its request while the next is full.
// Reset (arst_n low): all pipeline valids clear; identity_mode 0, point_count 5 and the
// five default calibration points load.
module piecewise_linear_percent_to_byte_core #(
	parameter int MAX_POINTS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [15:0]                           s_tdata,   // [15:0] percent_q8
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata,   // [7:0] raw_value
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [plpb_pkg::IDX_W-1:0]            cfg_index,
	input  logic [plpb_pkg::PAIR_W-1:0]           cfg_data
);

	logic                       identity_q;
	logic [plpb_pkg::CNT_W-1:0] count_q;
	plpb_pkg::pairs_t           pairs_q;

	logic                       seg_valid, seg_ready;
	plpb_pkg::seg_t             seg_data;
	logic                       div_valid, div_ready;
	plpb_pkg::div_t             div_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			identity_q <= 1'b0;
			count_q    <= plpb_pkg::COUNT_RST;
			pairs_q[0] <= plpb_pkg::PAIR0_RST;
			pairs_q[1] <= plpb_pkg::PAIR1_RST;
			pairs_q[2] <= plpb_pkg::PAIR2_RST;
			pairs_q[3] <= plpb_pkg::PAIR3_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				plpb_pkg::REG_IDENTITY: identity_q <= cfg_data[0];
				plpb_pkg::REG_COUNT:    count_q    <= cfg_data[plpb_pkg::CNT_W-1:0];
				plpb_pkg::REG_PAIR0:    pairs_q[0] <= cfg_data;
				plpb_pkg::REG_PAIR1:    pairs_q[1] <= cfg_data;
				plpb_pkg::REG_PAIR2:    pairs_q[2] <= cfg_data;
				plpb_pkg::REG_PAIR3:    pairs_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	plpb_seg #(
		.MAX_POINTS(MAX_POINTS)
	) u_seg (
		.clk          (clk),
		.arst_n       (arst_n),
		.identity_mode(identity_q),
		.point_count  (count_q),
		.pairs        (pairs_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_pct       (s_tdata),
		.out_valid    (seg_valid),
		.out_ready    (seg_ready),
		.out_seg      (seg_data)
	);

	plpb_arith u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (seg_valid),
		.in_ready (seg_ready),
		.in_seg   (seg_data),
		.out_valid(div_valid),
		.out_ready(div_ready),
		.out_div  (div_data)
	);

	plpb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid),
		.in_ready (div_ready),
		.in_div   (div_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_quo  (m_tdata)
	);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output stage");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> seg_valid)
		else $error("accepted request missing from first stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |=> seg_valid && $stable(seg_data))
		else $error("stalled first stage lost or changed its request");

endmodule

[rtl/plpb_seg.sv]
module plpb_seg #(
	parameter int MAX_POINTS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        identity_mode,
	input  logic [plpb_pkg::CNT_W-1:0]  point_count,
	input  plpb_pkg::pairs_t            pairs,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [plpb_pkg::PCT_W-1:0]  in_pct,
	output logic                        out_valid,
	input  logic                        out_ready,
	output plpb_pkg::seg_t              out_seg
);

	logic [plpb_pkg::PCT_W-1:0] pct [MAX_POINTS];
	logic [plpb_pkg::RAW_W-1:0] raw [MAX_POINTS];
	logic [plpb_pkg::CNT_W-1:0] n_eff;
	logic [plpb_pkg::PCT_W-1:0] pl;
	logic [plpb_pkg::RAW_W-1:0] rl;
	logic                       found;
	logic [plpb_pkg::PCT_W-1:0] sap, sbp;
	logic [plpb_pkg::RAW_W-1:0] sar, sbr;
	plpb_pkg::seg_t             nxt;
	plpb_pkg::seg_t             seg_s1;
	logic                       v_s1;

	for (genvar g = 0; g < MAX_POINTS; g++) begin : g_unpack
		assign pct[g] = pairs[g >> 1][((g & 1) * plpb_pkg::PT_W) + plpb_pkg::RAW_W +: plpb_pkg::PCT_W];
		assign raw[g] = pairs[g >> 1][((g & 1) * plpb_pkg::PT_W) +: plpb_pkg::RAW_W];
	end

	always_comb begin
		n_eff = (point_count > plpb_pkg::CNT_W'(MAX_POINTS)) ?
			plpb_pkg::CNT_W'(MAX_POINTS) : point_count;
		pl = pct[0];
		rl = raw[0];
		for (int i = 0; i < MAX_POINTS; i++) begin
			if (plpb_pkg::CNT_W'(i + 1) == n_eff) begin
				pl = pct[i];
				rl = raw[i];
			end
		end
		found = 1'b0;
		sap = pct[0];
		sbp = pct[0];
		sar = raw[0];
		sbr = raw[0];
		for (int i = 0; i < MAX_POINTS - 1; i++) begin
			if (!found && plpb_pkg::CNT_W'(i + 2) <= n_eff &&
					pct[i] <= in_pct && in_pct <= pct[i+1]) begin
				found = 1'b1;
				sap = pct[i];
				sbp = pct[i+1];
				sar = raw[i];
				sbr = raw[i+1];
			end
		end
	end

	always_comb begin
		nxt = '0;
		nxt.p = in_pct;
		nxt.ap = sap;
		nxt.bp = sbp;
		nxt.ar = sar;
		nxt.br = sbr;
		if (!identity_mode && n_eff != '0 && in_pct <= pct[0]) begin
			nxt.dir = 1'b1;
			nxt.val = raw[0];
		end else if (!identity_mode && n_eff != '0 && in_pct >= pl) begin
			nxt.dir = 1'b1;
			nxt.val = rl;
		end else if (!identity_mode && n_eff != '0 && found) begin
			nxt.dir = 1'b0;
		end else if (in_pct >= plpb_pkg::LIN_SAT_P) begin
			nxt.dir = 1'b1;
			nxt.val = plpb_pkg::RAW_MAX;
		end else begin
			nxt.lin = 1'b1;
		end
	end

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			seg_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_seg   = seg_s1;

endmodule

[rtl/plpb_arith.sv]
module plpb_arith (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  plpb_pkg::seg_t  in_seg,
	output logic            out_valid,
	input  logic            out_ready,
	output plpb_pkg::div_t  out_div
);

	logic                              v_s2, v_s3, v_s4;
	logic                              en2, en3, en4;
	logic                              dir_s2, lin_s2;
	logic [plpb_pkg::RAW_W-1:0]        val_s2, ar_s2;
	logic [plpb_pkg::PCT_W-1:0]        p_s2, d_s2, t_s2;
	logic signed [plpb_pkg::RAW_W:0]   diff_s2;
	logic                              dir_s3, lin_s3;
	logic [plpb_pkg::RAW_W-1:0]        val_s3;
	logic [plpb_pkg::PCT_W-1:0]        d_s3;
	logic [plpb_pkg::LIN_W-1:0]        prod_a_s3;
	logic signed [plpb_pkg::NUM_W:0]   prod_b_s3;
	logic [plpb_pkg::LIN_W-1:0]        lin_num_s3;
	logic signed [plpb_pkg::NUM_W:0]   total;
	plpb_pkg::div_t                    nxt4;
	plpb_pkg::div_t                    div_s4;

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign in_ready = en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en2) begin
				v_s2 <= in_valid;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && in_valid) begin
			dir_s2  <= in_seg.dir;
			lin_s2  <= in_seg.lin;
			val_s2  <= in_seg.val;
			ar_s2   <= in_seg.ar;
			p_s2    <= in_seg.p;
			d_s2    <= in_seg.bp - in_seg.ap;
			t_s2    <= in_seg.p - in_seg.ap;
			diff_s2 <= $signed({1'b0, in_seg.br}) - $signed({1'b0, in_seg.ar});
		end
		if (en3 && v_s2) begin
			dir_s3     <= dir_s2 || (!lin_s2 && d_s2 == '0);
			lin_s3     <= lin_s2;
			val_s3     <= dir_s2 ? val_s2 : ar_s2;
			d_s3       <= d_s2;
			prod_a_s3  <= plpb_pkg::LIN_W'(ar_s2) * plpb_pkg::LIN_W'(d_s2);
			prod_b_s3  <= (plpb_pkg::NUM_W + 1)'($signed({1'b0, t_s2})) *
				(plpb_pkg::NUM_W + 1)'(diff_s2);
			lin_num_s3 <= {p_s2, 8'b0} - {8'b0, p_s2} + plpb_pkg::LIN_BIAS;
		end
		if (en4 && v_s3) begin
			div_s4 <= nxt4;
		end
	end

	always_comb begin
		total = $signed({2'b00, prod_a_s3}) + prod_b_s3;
		nxt4.quo = '0;
		if (dir_s3) begin
			nxt4.rem = plpb_pkg::NUM_W'(val_s3);
			nxt4.den = plpb_pkg::DEN_W'(1);
		end else if (lin_s3) begin
			nxt4.rem = plpb_pkg::NUM_W'(lin_num_s3);
			nxt4.den = plpb_pkg::LIN_DEN;
		end else begin
			nxt4.rem = {total[plpb_pkg::LIN_W-1:0], 1'b0} + plpb_pkg::NUM_W'(d_s3);
			nxt4.den = {d_s3, 1'b0};
		end
	end

	assign out_valid = v_s4;
	assign out_div   = div_s4;

endmodule

[rtl/plpb_div.sv]
module plpb_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  plpb_pkg::div_t              in_div,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [plpb_pkg::QUO_W-1:0]  out_quo
);

	localparam int STAGES = plpb_pkg::QUO_W;

	logic [STAGES-1:0] vld_s;
	logic [STAGES-1:0] en;
	plpb_pkg::div_t    dv_s [STAGES];

	always_comb begin
		en[STAGES-1] = !vld_s[STAGES-1] || out_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		plpb_pkg::div_t         src;
		plpb_pkg::div_t         nxt;
		logic                   src_v;
		logic [plpb_pkg::NUM_W-1:0] sub;

		if (k == 0) begin : g_first
			assign src   = in_div;
			assign src_v = in_valid;
		end else begin : g_rest
			assign src   = dv_s[k-1];
			assign src_v = vld_s[k-1];
		end

		always_comb begin
			sub = plpb_pkg::NUM_W'(src.den) << (STAGES - 1 - k);
			nxt = src;
			if (src.rem >= sub) begin
				nxt.rem = src.rem - sub;
				nxt.quo[STAGES-1-k] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && src_v) begin
				dv_s[k] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign out_quo   = dv_s[STAGES-1].quo;

endmodule
